@@ hw/rtl/lsoa_pkg.sv @@
// Shared types, constants and fixed-point helpers of the lidar sector obstacle avoider.
package lsoa_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_HALF_WIDTH   = 3'd0;
	localparam logic [2:0] REG_STOP_DIST    = 3'd1;
	localparam logic [2:0] REG_SECTOR_FIRST = 3'd2;
	localparam logic [2:0] REG_SECTOR_LAST  = 3'd3;
	localparam logic [2:0] REG_CENTER_INDEX = 3'd4;
	localparam logic [2:0] REG_CRUISE_SPEED = 3'd5;

	// Register values after reset.
	localparam logic [15:0] RST_HALF_WIDTH   = 16'd400;
	localparam logic [15:0] RST_STOP_DIST    = 16'd1000;
	localparam logic [8:0]  RST_SECTOR_FIRST = 9'd150;
	localparam logic [8:0]  RST_SECTOR_LAST  = 9'd209;
	localparam logic [8:0]  RST_CENTER_INDEX = 9'd180;
	localparam logic [9:0]  RST_CRUISE_SPEED = 10'd50;

	localparam logic [15:0]        NO_RETURN   = 16'hFFFF;
	localparam logic signed [16:0] NO_OBSTACLE = 17'sd65535;
	localparam logic [9:0]         SPEED_MAX   = 10'd1000;

	localparam int                 CORDIC_STEPS    = 30;
	localparam logic signed [63:0] CORDIC_GAIN_Q30 = 64'sd652032874;

	typedef struct packed {
		logic [15:0] half_width_mm;
		logic [15:0] stop_distance_mm;
		logic [8:0]  sector_first;
		logic [8:0]  sector_last;
		logic [8:0]  center_index;
		logic [9:0]  cruise_speed;
	} lsoa_cfg_t;

	// One sample after the geometry pipeline.
	typedef struct packed {
		logic               cand;
		logic signed [16:0] x_mm;
		logic [8:0]         beam;
		logic               last;
	} lsoa_point_t;

	// CORDIC rotation angles, full turn = 2^32.
	function automatic logic signed [63:0] lsoa_atan(input int k);
		logic signed [63:0] a;
		case (k)
			0:  a = 64'sd536870912;
			1:  a = 64'sd316933406;
			2:  a = 64'sd167458907;
			3:  a = 64'sd85004756;
			4:  a = 64'sd42667331;
			5:  a = 64'sd21354465;
			6:  a = 64'sd10679838;
			7:  a = 64'sd5340245;
			8:  a = 64'sd2670163;
			9:  a = 64'sd1335087;
			10: a = 64'sd667544;
			11: a = 64'sd333772;
			12: a = 64'sd166886;
			13: a = 64'sd83443;
			14: a = 64'sd41722;
			15: a = 64'sd20861;
			16: a = 64'sd10430;
			17: a = 64'sd5215;
			18: a = 64'sd2608;
			19: a = 64'sd1304;
			20: a = 64'sd652;
			21: a = 64'sd326;
			22: a = 64'sd163;
			23: a = 64'sd81;
			24: a = 64'sd41;
			25: a = 64'sd20;
			26: a = 64'sd10;
			27: a = 64'sd5;
			28: a = 64'sd3;
			29: a = 64'sd1;
			default: a = 64'sd0;
		endcase
		return a;
	endfunction

	// Q30 to Q1.15, rounded half up and saturated.
	function automatic logic signed [15:0] lsoa_to_q15(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + 64'sd16384) >>> 15;
		if (r > 64'sd32767) begin
			r = 64'sd32767;
		end else if (r < -64'sd32768) begin
			r = -64'sd32768;
		end
		return r[15:0];
	endfunction

endpackage

@@ hw/rtl/lsoa_trig_rom.sv @@
// Beam angle ROM holding -cos and sin in Q1.15, built at elaboration by CORDIC.
module lsoa_trig_rom import lsoa_pkg::*; #(
	parameter int ANGLE_STEPS = 360,
	parameter int AW = $clog2(ANGLE_STEPS)
) (
	input  logic                clk,
	input  logic                en,
	input  logic [AW-1:0]       addr,
	output logic signed [15:0]  negcos,
	output logic signed [15:0]  sin_v
);

	// Entry layout: sin in the upper half, -cos in the lower half.
	function automatic logic [31:0] trig_entry(input int idx);
		logic [63:0]        p;
		logic signed [63:0] z;
		logic signed [63:0] cx;
		logic signed [63:0] cy;
		logic signed [63:0] nx;
		logic               flip;
		logic signed [15:0] nc;
		logic signed [15:0] sn;
		p = ((64'(idx) << 32) + 64'(ANGLE_STEPS / 2)) / 64'(ANGLE_STEPS);
		z = $signed({32'd0, p[31:0]});
		cx = CORDIC_GAIN_Q30;
		cy = 64'sd0;
		flip = 1'b0;
		if (z >= 64'sd2147483648) begin
			z = z - 64'sd4294967296;
		end
		if (z > 64'sd1073741824) begin
			z = z - 64'sd2147483648;
			flip = 1'b1;
		end else if (z < -64'sd1073741824) begin
			z = z + 64'sd2147483648;
			flip = 1'b1;
		end
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			if (z >= 64'sd0) begin
				nx = cx - (cy >>> k);
				cy = cy + (cx >>> k);
				z  = z - lsoa_atan(k);
			end else begin
				nx = cx + (cy >>> k);
				cy = cy - (cx >>> k);
				z  = z + lsoa_atan(k);
			end
			cx = nx;
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		nc = lsoa_to_q15(-cx);
		sn = lsoa_to_q15(cy);
		return {sn, nc};
	endfunction

	logic [31:0] rom_entry [ANGLE_STEPS];

	for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_rom
		localparam logic [31:0] ENTRY = trig_entry(i);
		assign rom_entry[i] = ENTRY;
	end

	logic [31:0] rd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_q <= rom_entry[addr];
		end
	end

	assign negcos = $signed(rd_q[15:0]);
	assign sin_v  = $signed(rd_q[31:16]);

endmodule

@@ hw/rtl/lsoa_point.sv @@
// Geometry pipeline: table lookup, polar to x and y, corridor and sector test.
module lsoa_point import lsoa_pkg::*; #(
	parameter int ANGLE_STEPS = 360
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lsoa_cfg_t   cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] in_range,
	input  logic [8:0]  in_beam,
	input  logic        in_last,
	output logic        pt_valid,
	input  logic        pt_ready,
	output lsoa_point_t pt
);

	localparam int AW = $clog2(ANGLE_STEPS);

	logic               s1_v, s2_v, s3_v;
	logic               s1_ready, s2_ready, s3_ready;
	logic [15:0]        range_s1;
	logic [8:0]         beam_s1;
	logic               last_s1;
	logic signed [15:0] negcos_s1, sin_s1;

	logic signed [32:0] xq_s2, yq_s2;
	logic               sel_s2;
	logic [8:0]         beam_s2;
	logic               last_s2;

	lsoa_point_t        pt_s3;

	assign s3_ready = !s3_v || pt_ready;
	assign s2_ready = !s2_v || s3_ready;
	assign s1_ready = !s1_v || s2_ready;
	assign in_ready = s1_ready;

	lsoa_trig_rom #(
		.ANGLE_STEPS(ANGLE_STEPS),
		.AW(AW)
	) u_rom (
		.clk(clk),
		.en(in_valid && s1_ready),
		.addr(AW'(in_beam)),
		.negcos(negcos_s1),
		.sin_v(sin_s1)
	);

	// Stage 1: sample register beside the ROM read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s1_ready) begin
			s1_v <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_ready) begin
			range_s1 <= in_range;
			beam_s1  <= in_beam;
			last_s1  <= in_last;
		end
	end

	// Stage 2: both products and the beam selection.
	logic signed [16:0] range_sx;
	logic               sel_c;

	assign range_sx = $signed({1'b0, range_s1});
	assign sel_c = (range_s1 != NO_RETURN) && (32'(beam_s1) < 32'(ANGLE_STEPS)) &&
		(beam_s1 >= cfg.sector_first) && (beam_s1 <= cfg.sector_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_ready) begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v && s2_ready) begin
			xq_s2   <= range_sx * negcos_s1;
			yq_s2   <= range_sx * sin_s1;
			sel_s2  <= sel_c;
			beam_s2 <= beam_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: corridor test on |y| and rounding of x to millimetres.
	logic signed [32:0] yabs;
	logic [32:0]        limit;
	logic signed [33:0] xsum;
	logic signed [33:0] xshift;

	assign yabs   = (yq_s2 < 0) ? -yq_s2 : yq_s2;
	assign limit  = {2'b00, cfg.half_width_mm, 15'd0};
	assign xsum   = 34'(xq_s2) + 34'sd16384;
	assign xshift = xsum >>> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v <= 1'b0;
		end else if (s3_ready) begin
			s3_v <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_v && s3_ready) begin
			pt_s3.cand <= sel_s2 && ($unsigned(yabs) < limit);
			pt_s3.x_mm <= xshift[16:0];
			pt_s3.beam <= beam_s2;
			pt_s3.last <= last_s2;
		end
	end

	assign pt_valid = s3_v;
	assign pt       = pt_s3;

endmodule

@@ hw/rtl/lsoa_tracker.sv @@
// Nearest-point tracker and drive command register.
module lsoa_tracker import lsoa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lsoa_cfg_t          cfg,
	input  logic               pt_valid,
	output logic               pt_ready,
	input  lsoa_point_t        pt,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output logic [9:0]         forward_speed,
	output logic signed [10:0] lateral_speed,
	output logic signed [16:0] nearest_x_mm,
	output logic [8:0]         nearest_beam
);

	logic signed [16:0] best_x_q;
	logic [8:0]         best_beam_q;
	logic               out_v_q;
	logic               out_free;
	logic               consume;
	logic               win;
	logic signed [16:0] new_x;
	logic [8:0]         new_beam;
	logic [9:0]         speed;
	logic signed [10:0] speed_s;
	logic               stop;

	assign out_free = !out_v_q || cmd_ready;
	// A scan end needs the command register; other samples always pass.
	assign pt_ready = !pt.last || out_free;
	assign consume  = pt_valid && pt_ready;

	assign win      = pt.cand && (pt.x_mm < best_x_q);
	assign new_x    = win ? pt.x_mm : best_x_q;
	assign new_beam = win ? pt.beam : best_beam_q;
	assign speed    = (cfg.cruise_speed > SPEED_MAX) ? SPEED_MAX : cfg.cruise_speed;
	assign speed_s  = $signed({1'b0, speed});
	assign stop     = new_x < $signed({1'b0, cfg.stop_distance_mm});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_x_q    <= NO_OBSTACLE;
			best_beam_q <= RST_CENTER_INDEX;
		end else if (consume) begin
			if (pt.last) begin
				best_x_q    <= NO_OBSTACLE;
				best_beam_q <= cfg.center_index;
			end else begin
				best_x_q    <= new_x;
				best_beam_q <= new_beam;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (consume && pt.last) begin
			out_v_q <= 1'b1;
		end else if (cmd_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && pt.last) begin
			nearest_x_mm <= new_x;
			nearest_beam <= new_beam;
			if (stop) begin
				forward_speed <= 10'd0;
				lateral_speed <= (new_beam < cfg.center_index) ? speed_s : -speed_s;
			end else begin
				forward_speed <= speed;
				lateral_speed <= 11'sd0;
			end
		end
	end

	assign cmd_valid = out_v_q;

	// A scan end never overwrites a command that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt.last && out_v_q && !cmd_ready |-> !consume)
		else $error("scan end taken while command register is full");

	// Every consumed scan end presents a command on the next cycle.
	a_cmd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		consume && pt.last |=> out_v_q)
		else $error("scan end produced no command");

	// The tracker is cleared when a scan end is consumed, as its command is loaded.
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		consume && pt.last |=> best_x_q == NO_OBSTACLE)
		else $error("tracker not cleared after scan end");

	// A stop command always carries a corridor point nearer than the stop distance.
	a_stop_near: assert property (@(posedge clk) disable iff (!arst_n)
		consume && pt.last && stop |-> new_x != NO_OBSTACLE || cfg.stop_distance_mm == 16'hFFFF)
		else $error("stop issued without an obstacle");

endmodule

@@ hw/rtl/lidar_sector_obstacle_avoider.sv @@
// Top level of the lidar sector obstacle avoider: stream ports, registers, pipeline.
//
// The block takes one lidar sample per request on the slave stream (range in
// millimetres and beam index, beams in ascending order, tlast on the final beam
// of a scan) and sustains one sample per clock cycle. Each sample looks up -cos
// and sin of its beam in a ROM of ANGLE_STEPS Q1.15 entries that is built at
// elaboration, is turned into x and y by two 17 x 16 multipliers, and, when its
// beam lies within sector_first..sector_last, its range is not the no-return
// code 65535 and |y| is below half_width_mm, competes for the least x; the first
// of equal points is kept. On the scan's last sample one drive command is
// presented on the master stream once the sample has passed the ROM read,
// the products, the rounding and corridor test and the tracker update into
// the command register, and the tracker is cleared to x = 65535 at
// center_index. The command stops and sidesteps at cruise speed (left when
// the nearest beam lies below center_index, right otherwise) if the nearest
// x is below stop_distance_mm, and otherwise drives straight at cruise speed,
// which is limited to 1000. Samples keep flowing while a command waits; only
// a scan's last sample is held when the previous command has not yet been
// taken, and that backs the pipeline up to the input. The user must write
// registers through the plain write port only while no scan is in flight;
// the block does not enforce this. Unknown indexes are ignored.
module lidar_sector_obstacle_avoider import lsoa_pkg::*; #(
	parameter int ANGLE_STEPS = 360
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Sample stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // range_mm [15:0], beam_index [24:16], zero [31:25]
	input  logic        s_axis_tlast,   // scan_last
	// Drive command stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // forward_speed [9:0], lateral_speed [20:10],
	                                    // nearest_x_mm [37:21], nearest_beam [46:38], zero [47]
);

	// Configuration registers, reset to their documented defaults.
	lsoa_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_width_mm    <= RST_HALF_WIDTH;
			cfg_q.stop_distance_mm <= RST_STOP_DIST;
			cfg_q.sector_first     <= RST_SECTOR_FIRST;
			cfg_q.sector_last      <= RST_SECTOR_LAST;
			cfg_q.center_index     <= RST_CENTER_INDEX;
			cfg_q.cruise_speed     <= RST_CRUISE_SPEED;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HALF_WIDTH:   cfg_q.half_width_mm    <= cfg_data;
				REG_STOP_DIST:    cfg_q.stop_distance_mm <= cfg_data;
				REG_SECTOR_FIRST: cfg_q.sector_first     <= cfg_data[8:0];
				REG_SECTOR_LAST:  cfg_q.sector_last      <= cfg_data[8:0];
				REG_CENTER_INDEX: cfg_q.center_index     <= cfg_data[8:0];
				REG_CRUISE_SPEED: cfg_q.cruise_speed     <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Geometry pipeline to tracker.
	logic               pt_valid;
	logic               pt_ready;
	lsoa_point_t        pt;

	lsoa_point #(
		.ANGLE_STEPS(ANGLE_STEPS)
	) u_point (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_range(s_axis_tdata[15:0]),
		.in_beam(s_axis_tdata[24:16]),
		.in_last(s_axis_tlast),
		.pt_valid(pt_valid),
		.pt_ready(pt_ready),
		.pt(pt)
	);

	logic [9:0]         forward_speed;
	logic signed [10:0] lateral_speed;
	logic signed [16:0] nearest_x_mm;
	logic [8:0]         nearest_beam;

	lsoa_tracker u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pt_valid(pt_valid),
		.pt_ready(pt_ready),
		.pt(pt),
		.cmd_valid(m_axis_tvalid),
		.cmd_ready(m_axis_tready),
		.forward_speed(forward_speed),
		.lateral_speed(lateral_speed),
		.nearest_x_mm(nearest_x_mm),
		.nearest_beam(nearest_beam)
	);

	assign m_axis_tdata = {1'b0, nearest_beam, nearest_x_mm, lateral_speed, forward_speed};

endmodule

@@ dv/lidar_sector_obstacle_avoider_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the lidar sector obstacle avoider: directed and random scans.
module lidar_sector_obstacle_avoider_tb;
	import lsoa_pkg::*;

	// The table size must match the block; it is passed down as the parameter.
	localparam int TRIG_STEPS   = 360;
	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 9;
	// A request passes the geometry stages and the tracker before it reaches the
	// command register, so the idle tail leaves the block empty before a register
	// write or the end of the run.
	localparam int TAIL_CYCLES  = 12;
	// The limit lies far above the length of the slowest correct run.
	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 85;

	// Indexes beyond the register file; writes to them must change nothing.
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	// CORDIC phase arithmetic, full turn = 2^32.
	localparam longint QUARTER_TURN = 64'sd1073741824;
	localparam longint HALF_TURN    = 64'sd2147483648;
	localparam longint FULL_TURN    = 64'sd4294967296;
	localparam longint Q15_HALF     = 64'sd16384;

	// One drive command as it leaves the master stream.
	typedef struct packed {
		logic [9:0]         forward_speed;
		logic signed [10:0] lateral_speed;
		logic signed [16:0] nearest_x_mm;
		logic [8:0]         nearest_beam;
	} drive_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // range_mm [15:0], beam_index [24:16], zero [31:25]
	logic        s_axis_tlast;   // scan_last
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // forward_speed [9:0], lateral_speed [20:10],
	                             // nearest_x_mm [37:21], nearest_beam [46:38], zero [47]

	lidar_sector_obstacle_avoider #(
		.ANGLE_STEPS(TRIG_STEPS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Trigonometry table: -cos and sin of every beam in Q1.15, built by the
	// same 30-step integer CORDIC the block is specified with.
	// ------------------------------------------------------------------
	longint rot_angle [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};
	int negcos_tab [TRIG_STEPS];
	int sin_tab [TRIG_STEPS];

	// Q30 to Q1.15, rounding half up; +1.0 saturates to 32767.
	function automatic int round_sat_q15(input longint q30);
		longint r;
		r = (q30 + Q15_HALF) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return int'(r);
	endfunction

	function automatic void build_trig_table();
		longint ph;
		longint z, cx, cy, nx;
		bit     flip;
		for (int i = 0; i < TRIG_STEPS; i++) begin
			ph = ((longint'(i) << 32) + TRIG_STEPS / 2) / TRIG_STEPS;
			z = ph & 64'hFFFF_FFFF;
			if (z >= HALF_TURN) z -= FULL_TURN;
			// Fold the two rear quadrants onto the front ones and negate at the end.
			flip = 1'b0;
			if (z > QUARTER_TURN) begin
				z -= HALF_TURN;
				flip = 1'b1;
			end else if (z < -QUARTER_TURN) begin
				z += HALF_TURN;
				flip = 1'b1;
			end
			cx = CORDIC_GAIN_Q30;
			cy = 0;
			for (int k = 0; k < 30; k++) begin
				if (z >= 0) begin
					nx = cx - (cy >>> k);
					cy = cy + (cx >>> k);
					z -= rot_angle[k];
				end else begin
					nx = cx + (cy >>> k);
					cy = cy - (cx >>> k);
					z += rot_angle[k];
				end
				cx = nx;
			end
			if (flip) begin
				cx = -cx;
				cy = -cy;
			end
			negcos_tab[i] = round_sat_q15(-cx);
			sin_tab[i] = round_sat_q15(cy);
		end
	endfunction

	// ------------------------------------------------------------------
	// Predictor: register copies, nearest-point tracker and the queue of
	// drive commands still to come out of the block.
	// ------------------------------------------------------------------
	int hw_cfg, stop_cfg, first_cfg, last_cfg, center_cfg, cruise_cfg;
	int best_x_mm, best_beam_idx;
	drive_cmd_t pending_cmds [$];

	int n_requests, n_commands, n_settings, n_fail;
	int n_left, n_right, n_straight, n_clear;

	// Runs one accepted request through the tracker and queues the drive
	// command when it closes a scan.
	function automatic void track_sample(input int rng, input int beam, input bit last);
		longint     ylat, xfwd;
		int         spd;
		drive_cmd_t cmd;
		if (rng != NO_RETURN && beam < TRIG_STEPS && beam >= first_cfg && beam <= last_cfg) begin
			ylat = longint'(rng) * sin_tab[beam];
			if (ylat < 0) ylat = -ylat;
			if (ylat < (longint'(hw_cfg) << 15)) begin
				xfwd = (longint'(rng) * negcos_tab[beam] + Q15_HALF) >>> 15;
				// Strict compare: the first of equally near points stays.
				if (xfwd < best_x_mm) begin
					best_x_mm = int'(xfwd);
					best_beam_idx = beam;
				end
			end
		end
		if (last) begin
			spd = (cruise_cfg > int'(SPEED_MAX)) ? int'(SPEED_MAX) : cruise_cfg;
			if (best_x_mm < stop_cfg) begin
				cmd.forward_speed = '0;
				if (best_beam_idx < center_cfg) begin
					cmd.lateral_speed = 11'(spd);
					n_left++;
				end else begin
					cmd.lateral_speed = 11'(-spd);
					n_right++;
				end
			end else begin
				cmd.forward_speed = 10'(spd);
				cmd.lateral_speed = '0;
				n_straight++;
				if (best_x_mm == NO_OBSTACLE) n_clear++;
			end
			cmd.nearest_x_mm = 17'(best_x_mm);
			cmd.nearest_beam = 9'(best_beam_idx);
			pending_cmds.push_back(cmd);
			// The tracker restarts at the center beam that is set right now.
			best_x_mm = NO_OBSTACLE;
			best_beam_idx = center_cfg;
		end
	endfunction

	// ------------------------------------------------------------------
	// Receiver side: tready is redrawn at every falling edge and is low with a
	// probability of recv_stall_pct percent.
	// ------------------------------------------------------------------
	int send_idle_pct, recv_stall_pct;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// Drive command checker: each accepted command is compared field by
	// field with the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_commands
		drive_cmd_t got, want;
		int         bad;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.forward_speed = m_axis_tdata[9:0];
			got.lateral_speed = m_axis_tdata[20:10];
			got.nearest_x_mm  = m_axis_tdata[37:21];
			got.nearest_beam  = m_axis_tdata[46:38];
			n_commands++;
			if (pending_cmds.size() == 0) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$display("%0t: drive command %0d arrived with none expected:",
						$realtime, n_commands,
						" fwd %0d lat %0d x %0d beam %0d",
						got.forward_speed, got.lateral_speed,
						got.nearest_x_mm, got.nearest_beam);
			end else begin
				want = pending_cmds.pop_front();
				bad = 0;
				if (got.forward_speed !== want.forward_speed) bad++;
				if (got.lateral_speed !== want.lateral_speed) bad++;
				if (got.nearest_x_mm !== want.nearest_x_mm) bad++;
				if (got.nearest_beam !== want.nearest_beam) bad++;
				if (bad != 0) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS)
						$display("%0t: drive command %0d, %0d field(s) wrong",
							$realtime, n_commands, bad,
							" (expected/actual): fwd %0d/%0d lat %0d/%0d",
							want.forward_speed, got.forward_speed,
							want.lateral_speed, got.lateral_speed,
							" x %0d/%0d beam %0d/%0d",
							want.nearest_x_mm, got.nearest_x_mm,
							want.nearest_beam, got.nearest_beam);
				end
			end
		end
	end

	// Watchdog on the whole run.
	int n_cycles;
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d commands outstanding.",
				n_cycles, pending_cmds.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender side. Every task starts and ends at a falling edge, so each
	// input changes once per cycle at most and is stable at the rising edge.
	// ------------------------------------------------------------------
	task automatic send_sample(input int rng, input int beam, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, 9'(beam), 16'(rng)};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		track_sample(rng, beam, last);
		n_requests++;
		@(negedge clk);
	endtask

	// Stops sending and waits until every predicted command has come out,
	// then lets the pipeline run empty.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// Register writes are held high across a batch and lowered by end_writes.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		case (idx)
			REG_HALF_WIDTH:   hw_cfg = data;
			REG_STOP_DIST:    stop_cfg = data;
			REG_SECTOR_FIRST: first_cfg = data[8:0];
			REG_SECTOR_LAST:  last_cfg = data[8:0];
			REG_CENTER_INDEX: center_cfg = data[8:0];
			REG_CRUISE_SPEED: cruise_cfg = data[9:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Writes the whole register set with the block idle. The narrow registers
	// get random bits above their width, which the block must drop.
	task automatic set_config(input int hw, input int sd, input int sf, input int sl,
			input int ci, input int cs);
		drain();
		write_reg(REG_HALF_WIDTH, 16'(hw));
		write_reg(REG_STOP_DIST, 16'(sd));
		write_reg(REG_SECTOR_FIRST, {7'($urandom), 9'(sf)});
		write_reg(REG_SECTOR_LAST, {7'($urandom), 9'(sl)});
		write_reg(REG_CENTER_INDEX, {7'($urandom), 9'(ci)});
		write_reg(REG_CRUISE_SPEED, {6'($urandom), 10'(cs)});
		end_writes();
		n_settings++;
	endtask

	// Range mix: many returns near the stop distance so that sidesteps are
	// common, plus no-return codes, zero ranges and the full field.
	function automatic int pick_range();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10) return NO_RETURN;
		if (sel < 15) return 0;
		if (sel < 50) return $urandom_range((stop_cfg * 2 + 100 > 65534) ? 65534 : stop_cfg * 2 + 100);
		if (sel < 75) return $urandom_range(3000);
		return $urandom_range(65535);
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset register values: an obstacle straight ahead makes the robot step
	// right, a scan with nothing in the corridor drives straight on.
	task automatic test_reset_defaults();
		send_sample(800, 180, 1'b0);
		send_sample(2000, 170, 1'b0);
		send_sample(NO_RETURN, 179, 1'b1);
		send_sample(1500, 200, 1'b1);
	endtask

	task automatic test_special_cases();
		// Zero ranges tie at x = 0; the earlier beam, right of center, wins.
		send_sample(0, 185, 1'b0);
		send_sample(0, 186, 1'b1);
		// An obstacle left of center.
		send_sample(300, 175, 1'b1);
		// A lone no-return sample is never an obstacle.
		send_sample(NO_RETURN, 180, 1'b1);

		// Widest sector, center at beam 0, fast cruise saturating at 1000.
		// The spare indexes are written too and must leave everything alone.
		drain();
		write_reg(REG_HALF_WIDTH, 16'hFFFF);
		write_reg(REG_STOP_DIST, 16'hFFFF);
		write_reg(REG_SECTOR_FIRST, 16'd0);
		write_reg(REG_SECTOR_LAST, 16'd511);
		write_reg(REG_CENTER_INDEX, 16'd0);
		write_reg(REG_CRUISE_SPEED, 16'hFFFF);
		write_reg(REG_SPARE_A, 16'd0);
		write_reg(REG_SPARE_B, 16'hFFFF);
		end_writes();
		n_settings++;
		// Beams past the end of the table are never obstacles.
		send_sample(10, 400, 1'b0);
		send_sample(0, 511, 1'b1);
		// Longest range behind the robot gives the most negative x.
		send_sample(65534, 0, 1'b1);

		// Sector whose first beam lies beyond its last: nothing is searched.
		set_config(400, 1000, 300, 100, 180, 50);
		send_sample(100, 180, 1'b1);
		// Zero half width: no point is strictly inside the corridor.
		set_config(0, 1000, 150, 209, 180, 50);
		send_sample(100, 180, 1'b1);
		// Zero stop distance: only points behind the robot make it stop.
		set_config(400, 0, 0, 359, 180, 50);
		send_sample(500, 0, 1'b0);
		send_sample(50, 359, 1'b1);
	endtask

	task automatic test_register_extremes();
		set_config(65535, 0, 0, 359, 359, 0);
		send_sample(0, 180, 1'b0);
		send_sample(65535, 359, 1'b1);
		set_config(1, 65535, 359, 359, 0, 1000);
		send_sample(0, 359, 1'b0);
		send_sample(40000, 358, 1'b1);
	endtask

	// Random register settings and scans under each idling pattern. Most
	// stimulus is well-formed ascending scans around the sector; the rest is
	// single stray requests and scans at random places.
	task automatic test_random_scans();
		int made, n, beam, sf, sl, ci, hw, sd;
		bit open_scan, stray;
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				sf = $urandom_range(359);
				sl = ($urandom_range(4) == 0) ? $urandom_range(511) : sf + $urandom_range(80);
				if (sl > 511) sl = 511;
				if ($urandom_range(7) == 0) begin
					sf = 0;
					sl = 511;
				end
				ci = ($urandom_range(3) == 0) ? $urandom_range(511)
					: (sf + sl) / 2 + $urandom_range(10) - 5;
				if (ci < 0) ci = 0;
				if (ci > 511) ci = 511;
				hw = ($urandom_range(9) < 7) ? $urandom_range(1500, 50)
					: $urandom_range(65535);
				sd = ($urandom_range(9) < 7) ? $urandom_range(4000) : $urandom_range(65535);
				set_config(hw, sd, sf, sl, ci, $urandom_range(1023));
				made = 0;
				open_scan = 1'b0;
				while (made < RANDOM_ITEMS) begin
					if ($urandom_range(9) == 0) begin
						// A stray request anywhere, sometimes closing a scan.
						stray = ($urandom_range(3) == 0);
						send_sample($urandom_range(65535), $urandom_range(511), stray);
						open_scan = !stray;
						made++;
					end else begin
						n = $urandom_range(40, 1);
						beam = ($urandom_range(7) == 0) ? $urandom_range(511)
							: first_cfg - $urandom_range(5);
						if (beam < 0) beam = 0;
						for (int k = 0; k < n; k++) begin
							send_sample(pick_range(), beam, k == n - 1);
							beam += ($urandom_range(3) == 0) ? $urandom_range(6, 2) : 1;
							if (beam > 511) beam = 511;
						end
						open_scan = 1'b0;
						made += n;
					end
				end
				// Close the scan so the next settings start from a clean tracker.
				if (open_scan) send_sample(pick_range(), $urandom_range(511), 1'b1);
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		build_trig_table();
		hw_cfg        = RST_HALF_WIDTH;
		stop_cfg      = RST_STOP_DIST;
		first_cfg     = RST_SECTOR_FIRST;
		last_cfg      = RST_SECTOR_LAST;
		center_cfg    = RST_CENTER_INDEX;
		cruise_cfg    = RST_CRUISE_SPEED;
		best_x_mm     = NO_OBSTACLE;
		best_beam_idx = RST_CENTER_INDEX;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_reset_defaults();
		test_special_cases();
		test_register_extremes();
		test_random_scans();

		drain();
		n_fail += pending_cmds.size();
		$display("Sent %0d requests and checked %0d drive commands under %0d register settings.",
			n_requests, n_commands, n_settings);
		$display("Predicted %0d left and %0d right sidesteps, %0d straight runs",
			n_left, n_right, n_straight, " (%0d with a clear corridor).", n_clear);
		if (n_fail == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d failure(s).", n_fail);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
